>>> sv/shc_pkg.sv
// shc_pkg: widths, types, codes and color tables for the slope/height colorizer.
// Used by the channel interfaces and by every module of the block.
// Depends on nothing.
package shc_pkg;

    // Sample and register formats
    localparam int HEIGHT_BITS    = 8;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int SNOW_W         = 8;
    localparam int COLOR_W        = 8;
    localparam int CLASS_W        = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int HMAX           = (1 << HEIGHT_BITS) - 1;

    // Square root: root of (sum of squares << 2*SQRT_FRAC), radicand padded to even width
    localparam int SQ_W       = 2 * HEIGHT_BITS + 1;
    localparam int SQRT_FRAC  = 8;
    localparam int RAD_RAW_W  = SQ_W + 2 * SQRT_FRAC;
    localparam int RAD_W      = RAD_RAW_W + (RAD_RAW_W % 2);
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQ_STAGES  = (ROOT_W + 1) / 2;

    // Blend arithmetic
    localparam int GR_W      = GAIN_W + ROOT_W;
    localparam int SUB_W     = GR_W + COLOR_W;
    localparam int DIV_SHIFT = GAIN_FRAC_BITS + 8;
    localparam int Q_W       = HEIGHT_BITS + 8;
    localparam int NUM_CH    = 3;

    localparam logic [SUB_W-1:0] DEN      = SUB_W'(HMAX) << DIV_SHIFT;
    localparam logic [SUB_W-1:0] HALF_DEN = DEN >> 1;
    localparam logic [GR_W-1:0]  ROCK_TH  = GR_W'(HMAX) << (GAIN_FRAC_BITS + 7);

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [SNOW_W-1:0] SNOW_RESET = SNOW_W'(204);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNOW_LEVEL = 1'b1;

    // Color channel indexes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Palette colors
    localparam logic [COLOR_W-1:0] SNOW_TOP    = 8'd255;
    localparam logic [COLOR_W-1:0] SNOW_BOTTOM = 8'd35;
    localparam logic [COLOR_W-1:0] GRASS_RED   = 8'd89;
    localparam logic [COLOR_W-1:0] GRASS_GREEN = 8'd189;
    localparam logic [COLOR_W-1:0] GRASS_BLUE  = 8'd64;
    localparam logic [COLOR_W-1:0] ROCK_TOP    = 8'd110;

    typedef enum logic [CLASS_W-1:0] {
        CLS_GRASS = 2'd0,
        CLS_ROCK  = 2'd1,
        CLS_SNOW  = 2'd2
    } t_class;

    // Front end to square root
    typedef struct packed {
        logic [SQ_W-1:0] sum_sq;
        logic            snow;
    } t_sq;

    // One square-root pipeline stage
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              snow;
    } t_sqst;

    // Square root to blend
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              snow;
    } t_root;

    // Start color of the blend for one channel
    function automatic logic [COLOR_W-1:0] top_color(t_class cls, logic [1:0] ch);
        logic [COLOR_W-1:0] c;
        case (cls)
            CLS_SNOW:  c = SNOW_TOP;
            CLS_ROCK:  c = ROCK_TOP;
            CLS_GRASS: begin
                case (ch)
                    CH_RED:   c = GRASS_RED;
                    CH_GREEN: c = GRASS_GREEN;
                    default:  c = GRASS_BLUE;
                endcase
            end
            default:   c = '0;
        endcase
        return c;
    endfunction

    // End color of the blend (same on all channels)
    function automatic logic [COLOR_W-1:0] bottom_color(t_class cls);
        logic [COLOR_W-1:0] c;
        case (cls)
            CLS_SNOW: c = SNOW_BOTTOM;
            default:  c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> sv/shc_in_if.sv
// shc_in_if: input channel of the colorizer, one height sample with its neighbors.
// Depends on shc_pkg for the field widths.
interface shc_in_if;
    logic                           valid;
    logic                           ready;
    logic [shc_pkg::HEIGHT_BITS-1:0] height_here;
    logic [shc_pkg::HEIGHT_BITS-1:0] height_prev_row;
    logic [shc_pkg::HEIGHT_BITS-1:0] height_next_row;
    logic [shc_pkg::HEIGHT_BITS-1:0] height_prev_col;
    logic [shc_pkg::HEIGHT_BITS-1:0] height_next_col;
    logic                           at_first_row;
    logic                           at_first_col;

    modport source (
        output valid, height_here, height_prev_row, height_next_row,
               height_prev_col, height_next_col, at_first_row, at_first_col,
        input  ready
    );

    modport sink (
        input  valid, height_here, height_prev_row, height_next_row,
               height_prev_col, height_next_col, at_first_row, at_first_col,
        output ready
    );
endinterface

>>> sv/shc_out_if.sv
// shc_out_if: output channel of the colorizer, one color and its terrain class.
// Depends on shc_pkg for the field widths.
interface shc_out_if;
    logic                         valid;
    logic                         ready;
    logic [shc_pkg::COLOR_W-1:0]  red;
    logic [shc_pkg::COLOR_W-1:0]  green;
    logic [shc_pkg::COLOR_W-1:0]  blue;
    logic [shc_pkg::CLASS_W-1:0]  terrain_class;

    modport source (
        output valid, red, green, blue, terrain_class,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, terrain_class,
        output ready
    );
endinterface

>>> sv/slope_height_colorizer.sv
// slope_height_colorizer: colors a height-map sample by its slope and height.
// Pipeline: register stages from input transaction to result (2 front, 9 square root, 4 blend).
// Throughput: one transaction per cycle when not stalled; a stage moves when empty or its successor moves.
// Reset: synchronous, active low; empties the pipeline, slope_gain = 1.0, snow_level = 204.
// Depends on shc_pkg, shc_in_if, shc_out_if, shc_front, shc_sqrt and shc_blend.
module slope_height_colorizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    shc_in_if.sink                          i_in,
    shc_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [shc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [shc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [shc_pkg::GAIN_W-1:0] r_slope_gain;
    logic [shc_pkg::SNOW_W-1:0] r_snow_level;

    logic           w_sq_valid;
    logic           w_sq_ready;
    shc_pkg::t_sq   w_sq_data;
    logic           w_rt_valid;
    logic           w_rt_ready;
    shc_pkg::t_root w_rt_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_gain <= shc_pkg::GAIN_RESET;
            r_snow_level <= shc_pkg::SNOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shc_pkg::CFG_SLOPE_GAIN: r_slope_gain <= i_cfg_data[shc_pkg::GAIN_W-1:0];
                shc_pkg::CFG_SNOW_LEVEL: r_snow_level <= i_cfg_data[shc_pkg::SNOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Differences and sum of squares
    shc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_snow_level (r_snow_level),
        .o_valid      (w_sq_valid),
        .i_ready      (w_sq_ready),
        .o_data       (w_sq_data)
    );

    // Slope magnitude
    shc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_sq_ready),
        .i_data  (w_sq_data),
        .o_valid (w_rt_valid),
        .i_ready (w_rt_ready),
        .o_data  (w_rt_data)
    );

    // Palette and blend
    shc_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_rt_valid),
        .o_ready      (w_rt_ready),
        .i_data       (w_rt_data),
        .i_slope_gain (r_slope_gain),
        .o_out        (o_out)
    );

endmodule

>>> sv/shc_front.sv
// shc_front: neighbor select, absolute differences, snow test and sum of squares.
// Two register stages. Depends on shc_pkg and shc_in_if.
module shc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    shc_in_if.sink                        i_in,
    input  logic [shc_pkg::SNOW_W-1:0]    i_snow_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output shc_pkg::t_sq                  o_data
);

    localparam int HB = shc_pkg::HEIGHT_BITS;

    logic          r_vld0;
    logic          r_vld1;
    logic          w_rdy0;
    logic          w_rdy1;
    logic [HB-1:0] r_diff_row;
    logic [HB-1:0] r_diff_col;
    logic          r_snow0;
    shc_pkg::t_sq  r_sq;

    logic [HB-1:0] n_diff_row;
    logic [HB-1:0] n_diff_col;
    logic          n_snow;
    logic [HB-1:0] w_nb_row;
    logic [HB-1:0] w_nb_col;
    logic [HB-1:0] w_snow_th;

    // Advance a stage when it is empty or its successor advances
    assign w_rdy1     = !r_vld1 || i_ready;
    assign w_rdy0     = !r_vld0 || w_rdy1;
    assign i_in.ready = w_rdy0;

    // Pick neighbors, take absolute differences, test the snow level
    always_comb begin
        w_nb_row   = i_in.at_first_row ? i_in.height_next_row : i_in.height_prev_row;
        w_nb_col   = i_in.at_first_col ? i_in.height_next_col : i_in.height_prev_col;
        n_diff_row = (i_in.height_here >= w_nb_row) ? i_in.height_here - w_nb_row
                                                    : w_nb_row - i_in.height_here;
        n_diff_col = (i_in.height_here >= w_nb_col) ? i_in.height_here - w_nb_col
                                                    : w_nb_col - i_in.height_here;
        w_snow_th  = HB'(i_snow_level) << (HB - shc_pkg::SNOW_W);
        n_snow     = i_in.height_here > w_snow_th;
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_vld0 <= i_in.valid;
            end
            if (w_rdy1) begin
                r_vld1 <= r_vld0;
            end
        end
    end

    // Stage payload: differences, then sum of squares
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_diff_row <= n_diff_row;
            r_diff_col <= n_diff_col;
            r_snow0    <= n_snow;
        end
        if (w_rdy1) begin
            r_sq.sum_sq <= shc_pkg::SQ_W'(r_diff_row) * shc_pkg::SQ_W'(r_diff_row)
                         + shc_pkg::SQ_W'(r_diff_col) * shc_pkg::SQ_W'(r_diff_col);
            r_sq.snow   <= r_snow0;
        end
    end

    assign o_valid = r_vld1;
    assign o_data  = r_sq;

endmodule

>>> sv/shc_sqrt.sv
// shc_sqrt: pipelined integer square root, two result bits per register stage (one in the last on an odd root width).
// Gives floor(sqrt(sum_sq << 16)) in Q.8. Depends on shc_pkg.
module shc_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  shc_pkg::t_sq   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output shc_pkg::t_root o_data
);

    localparam int NST = shc_pkg::SQ_STAGES;
    localparam int RW  = shc_pkg::ROOT_W;
    localparam int MW  = shc_pkg::REM_W;
    localparam int AW  = shc_pkg::RAD_W;

    logic [NST-1:0]  r_vld;
    logic [NST:0]    w_rdy;
    shc_pkg::t_sqst  r_st [NST];
    shc_pkg::t_sqst  n_st [NST];
    shc_pkg::t_sqst  w_init;

    // One restoring step: bring down two radicand bits, try to set one root bit
    function automatic shc_pkg::t_sqst sq_step(shc_pkg::t_sqst st);
        logic [MW+1:0]  rem_t;
        logic [MW+1:0]  trial;
        shc_pkg::t_sqst o;
        o     = st;
        rem_t = {st.rem, st.rad[AW-1 -: 2]};
        trial = (MW + 2)'({st.root, 2'b01});
        o.rad = st.rad << 2;
        if (rem_t >= trial) begin
            o.rem  = MW'(rem_t - trial);
            o.root = {st.root[RW-2:0], 1'b1};
        end else begin
            o.rem  = MW'(rem_t);
            o.root = {st.root[RW-2:0], 1'b0};
        end
        return o;
    endfunction

    // Ready chain from the output back to the input
    always_comb begin
        w_rdy[NST] = i_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s + 1];
        end
    end
    assign o_ready = w_rdy[0];

    // Scale the radicand and start from an empty root
    always_comb begin
        w_init.rad  = AW'(i_data.sum_sq) << (2 * shc_pkg::SQRT_FRAC);
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.snow = i_data.snow;
    end

    // Two steps per stage; the last stage drops its second step on an odd root width
    always_comb begin
        for (int s = 0; s < NST; s++) begin
            n_st[s] = sq_step((s == 0) ? w_init : r_st[(s == 0) ? 0 : s - 1]);
            if (2 * s + 1 < RW) begin
                n_st[s] = sq_step(n_st[s]);
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NST; s++) begin
            if (w_rdy[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_valid     = r_vld[NST-1];
    assign o_data.root = r_st[NST-1].root;
    assign o_data.snow = r_st[NST-1].snow;

endmodule

>>> sv/shc_blend.sv
// shc_blend: gain multiply, terrain class, color blend, rounding and output register.
// Four register stages, the last one drives the output channel.
// Depends on shc_pkg and shc_out_if.
module shc_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  shc_pkg::t_root              i_data,
    input  logic [shc_pkg::GAIN_W-1:0]  i_slope_gain,
    shc_out_if.source                   o_out
);

    localparam int HB  = shc_pkg::HEIGHT_BITS;
    localparam int NCH = shc_pkg::NUM_CH;
    localparam int SW  = shc_pkg::SUB_W;
    localparam int QW  = shc_pkg::Q_W;
    localparam int CW  = shc_pkg::COLOR_W;
    localparam int EW  = QW - HB;

    localparam logic [HB:0] HMAX_X  = (HB + 1)'(shc_pkg::HMAX);
    localparam logic [HB:0] HMAX_X2 = HMAX_X << 1;

    logic [3:0]                  r_vld;
    logic [4:0]                  w_rdy;

    logic [shc_pkg::GR_W-1:0]    r_gr;
    logic                        r_snow;
    logic [SW-1:0]               r_sub [NCH];
    shc_pkg::t_class             r_cls1;
    logic [QW-1:0]               r_q [NCH];
    shc_pkg::t_class             r_cls2;
    logic [CW-1:0]               r_color [NCH];
    shc_pkg::t_class             r_cls3;

    shc_pkg::t_class             n_cls;
    logic [SW-1:0]               n_sub [NCH];
    logic [QW-1:0]               n_q [NCH];
    logic [CW-1:0]               n_color [NCH];

    // Ready chain from the output register back to the input
    always_comb begin
        w_rdy[4] = o_out.ready;
        for (int s = 3; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s + 1];
        end
    end
    assign o_ready = w_rdy[0];

    // Classify and form k * gain * root for each channel
    always_comb begin
        logic [CW-1:0] k;
        if (r_snow) begin
            n_cls = shc_pkg::CLS_SNOW;
        end else if (r_gr < shc_pkg::ROCK_TH) begin
            n_cls = shc_pkg::CLS_GRASS;
        end else begin
            n_cls = shc_pkg::CLS_ROCK;
        end
        for (int c = 0; c < NCH; c++) begin
            k        = shc_pkg::top_color(n_cls, 2'(c)) - shc_pkg::bottom_color(n_cls);
            n_sub[c] = SW'(k) * SW'(r_gr);
        end
    end

    // Subtract from the scaled start color (zero unless it stays positive), add half, drop the power-of-two part
    always_comb begin
        logic [SW-1:0] base;
        logic [SW-1:0] num;
        for (int c = 0; c < NCH; c++) begin
            base = SW'(shc_pkg::top_color(r_cls1, 2'(c))) * shc_pkg::DEN;
            num  = base - r_sub[c] + shc_pkg::HALF_DEN;
            if (r_sub[c] >= base) begin
                n_q[c] = '0;
            end else begin
                n_q[c] = QW'(num >> shc_pkg::DIV_SHIFT);
            end
        end
    end

    // Divide by full scale: estimate by shift, correct by the remainder, saturate at the largest color value
    always_comb begin
        logic [EW-1:0] est;
        logic [HB:0]   rem;
        logic [EW:0]   quo;
        for (int c = 0; c < NCH; c++) begin
            est = r_q[c][QW-1:HB];
            rem = {1'b0, r_q[c][HB-1:0]} + (HB + 1)'(est);
            quo = {1'b0, est};
            if (rem >= HMAX_X2) begin
                quo = quo + (EW + 1)'(2);
            end else if (rem >= HMAX_X) begin
                quo = quo + (EW + 1)'(1);
            end
            if (quo > (EW + 1)'({CW{1'b1}})) begin
                n_color[c] = {CW{1'b1}};
            end else begin
                n_color[c] = CW'(quo);
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_gr   <= shc_pkg::GR_W'(i_slope_gain) * shc_pkg::GR_W'(i_data.root);
            r_snow <= i_data.snow;
        end
        if (w_rdy[1]) begin
            r_cls1 <= n_cls;
            for (int c = 0; c < NCH; c++) r_sub[c] <= n_sub[c];
        end
        if (w_rdy[2]) begin
            r_cls2 <= r_cls1;
            for (int c = 0; c < NCH; c++) r_q[c] <= n_q[c];
        end
        if (w_rdy[3]) begin
            r_cls3 <= r_cls2;
            for (int c = 0; c < NCH; c++) r_color[c] <= n_color[c];
        end
    end

    assign o_out.valid         = r_vld[3];
    assign o_out.red           = r_color[shc_pkg::CH_RED];
    assign o_out.green         = r_color[shc_pkg::CH_GREEN];
    assign o_out.blue          = r_color[shc_pkg::CH_BLUE];
    assign o_out.terrain_class = r_cls3;

endmodule
